[hw/rtl/pfra_pkg.sv]
// Shared types and constants for the page frame reference count allocator.
package pfra_pkg;

    localparam int FUNC_W = 2;
    localparam int PAGE_W = 10;
    localparam int CFG_W = 11;
    localparam int STAT_W = 3;
    localparam int LANES = 16;
    localparam int LANE_W = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
    localparam int CFG_MAX = (1 << CFG_W) - 1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_REF     = 2'd1,
        FUNC_UNREF   = 2'd2,
        FUNC_RESERVE = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_NO_FREE    = 3'd1,
        STAT_RESERVED   = 3'd2,
        STAT_ALR_FREE   = 3'd3,
        STAT_ALR_RESV   = 3'd4,
        STAT_OUT_RANGE  = 3'd5,
        STAT_OVERFLOW   = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_SCAN   = 2'd2,
        ST_MODIFY = 2'd3
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic scan;
        logic modify;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic scan_done;
    } t_dp_status;

endpackage

[hw/rtl/pfra_ctrl.sv]
// Controller state machine that sequences clearing, scans and single updates.
module pfra_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [pfra_pkg::FUNC_W-1:0]    i_func,
    input  pfra_pkg::t_dp_status           i_status,
    output pfra_pkg::t_dp_cmd              o_cmd,
    output logic                           busy
);

    pfra_pkg::t_state r_state;
    pfra_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfra_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            pfra_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = pfra_pkg::ST_IDLE;
                end
            end
            pfra_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    if (pfra_pkg::t_func'(i_func) == pfra_pkg::FUNC_ALLOC) begin
                        n_state = pfra_pkg::ST_SCAN;
                    end else begin
                        n_state = pfra_pkg::ST_MODIFY;
                    end
                end
            end
            pfra_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = pfra_pkg::ST_IDLE;
                end
            end
            pfra_pkg::ST_MODIFY: begin
                o_cmd.modify = 1'b1;
                n_state = pfra_pkg::ST_IDLE;
            end
            default: begin
                n_state = pfra_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != pfra_pkg::ST_IDLE);

endmodule

[hw/rtl/pfra_dp.sv]
// Datapath with the row-wide count store, used page total and result registers.
module pfra_dp #(
    parameter int NUM_PAGES = 1024,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pfra_pkg::t_dp_cmd              i_cmd,
    output pfra_pkg::t_dp_status           o_status_bus,
    input  logic [pfra_pkg::FUNC_W-1:0]    i_func,
    input  logic [pfra_pkg::PAGE_W-1:0]    i_page_number,
    input  logic                           i_cfg_valid,
    input  logic [pfra_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                           o_strobe,
    output logic [pfra_pkg::STAT_W-1:0]    o_status,
    output logic [pfra_pkg::PAGE_W-1:0]    o_granted_page,
    output logic [COUNT_WIDTH-1:0]         o_ref_count,
    output logic                           o_is_reserved,
    output logic [pfra_pkg::CFG_W-1:0]     o_used_pages,
    output logic [pfra_pkg::CFG_W-1:0]     o_free_pages
);

    localparam int ROWS = (NUM_PAGES + pfra_pkg::LANES - 1) / pfra_pkg::LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_BITS = pfra_pkg::LANES * COUNT_WIDTH;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COUNT_WIDTH-1:0] MARK = '1;
    localparam logic [pfra_pkg::CFG_W-1:0] NP_SAT =
        pfra_pkg::CFG_W'((NUM_PAGES > pfra_pkg::CFG_MAX) ? pfra_pkg::CFG_MAX : NUM_PAGES);

    logic [ROW_BITS-1:0] mem [ROWS];

    logic [ROW_BITS-1:0]            r_rdata;
    logic [ROW_W-1:0]               r_row;
    logic [ROW_W-1:0]               n_row;
    logic [pfra_pkg::CFG_W-1:0]     r_page_count;
    logic [pfra_pkg::CFG_W-1:0]     r_used;
    logic [pfra_pkg::CFG_W-1:0]     n_used;
    pfra_pkg::t_func                r_func;
    logic [pfra_pkg::PAGE_W-1:0]    r_page;
    logic                           r_strobe;
    pfra_pkg::t_status              r_status;
    logic [pfra_pkg::PAGE_W-1:0]    r_granted;
    logic [COUNT_WIDTH-1:0]         r_cnt;
    logic                           r_resv;
    logic [pfra_pkg::CFG_W-1:0]     r_free;

    logic [pfra_pkg::CFG_W-1:0]     lim;
    logic [31:0]                    in_page_ext;
    logic [31:0]                    page_ext;
    logic [31:0]                    row_base;
    logic [31:0]                    hit_page;
    logic [pfra_pkg::LANES-1:0]     cand;
    logic                           found;
    logic [pfra_pkg::LANE_W-1:0]    hit_lane;
    logic                           scan_last;
    logic [COUNT_WIDTH-1:0]         cur;
    logic                           rd_en;
    logic [ROW_W-1:0]               rd_addr;
    logic                           wr_en;
    logic [pfra_pkg::LANE_W-1:0]    wr_lane;
    logic [COUNT_WIDTH-1:0]         wr_val;
    logic [ROW_BITS-1:0]            wr_data;
    logic                           res_valid;
    pfra_pkg::t_status              res_status;
    logic [pfra_pkg::PAGE_W-1:0]    res_granted;
    logic [COUNT_WIDTH-1:0]         res_cnt;
    logic                           res_resv;
    logic [pfra_pkg::CFG_W-1:0]     res_free;
    logic                           scan_done;

    assign lim = (32'(r_page_count) < NUM_PAGES) ? r_page_count : NP_SAT;
    assign in_page_ext = 32'(i_page_number);
    assign page_ext = 32'(r_page);
    assign row_base = 32'(r_row) << pfra_pkg::LANE_W;
    assign cur = r_rdata[r_page[pfra_pkg::LANE_W-1:0] * COUNT_WIDTH +: COUNT_WIDTH];

    always_comb begin
        cand = '0;
        for (int l = 0; l < pfra_pkg::LANES; l++) begin
            cand[l] = ((row_base + 32'(l)) != 32'd0)
                && ((row_base + 32'(l)) < 32'(lim))
                && (r_rdata[l * COUNT_WIDTH +: COUNT_WIDTH] == '0);
        end
    end

    always_comb begin
        hit_lane = '0;
        for (int l = pfra_pkg::LANES - 1; l >= 0; l--) begin
            if (cand[l]) begin
                hit_lane = pfra_pkg::LANE_W'(l);
            end
        end
    end

    assign found = |cand;
    assign hit_page = row_base + 32'(hit_lane);
    assign scan_last = ((row_base + 32'(pfra_pkg::LANES)) >= 32'(lim)) || (r_row == LAST_ROW);

    always_comb begin
        rd_en = 1'b0;
        rd_addr = '0;
        wr_en = 1'b0;
        wr_lane = r_page[pfra_pkg::LANE_W-1:0];
        wr_val = '0;
        n_used = r_used;
        n_row = r_row;
        res_valid = 1'b0;
        res_status = pfra_pkg::STAT_OK;
        res_granted = '0;
        res_cnt = '0;
        res_resv = 1'b0;
        scan_done = 1'b0;

        if (i_cmd.clr_step) begin
            wr_en = 1'b1;
            n_row = (r_row == LAST_ROW) ? '0 : r_row + 1'b1;
        end

        if (i_cmd.accept) begin
            if (pfra_pkg::t_func'(i_func) == pfra_pkg::FUNC_ALLOC) begin
                rd_en = 1'b1;
                rd_addr = '0;
            end else begin
                rd_en = (in_page_ext < 32'(NUM_PAGES));
                rd_addr = in_page_ext[pfra_pkg::LANE_W +: ROW_W];
            end
            n_row = rd_addr;
        end

        if (i_cmd.scan) begin
            if (found) begin
                wr_en = 1'b1;
                wr_lane = hit_lane;
                wr_val = COUNT_WIDTH'(1);
                n_used = r_used + 1'b1;
                res_valid = 1'b1;
                res_granted = hit_page[pfra_pkg::PAGE_W-1:0];
                res_cnt = COUNT_WIDTH'(1);
                scan_done = 1'b1;
            end else if (scan_last) begin
                res_valid = 1'b1;
                res_status = pfra_pkg::STAT_NO_FREE;
                scan_done = 1'b1;
            end else begin
                rd_en = 1'b1;
                rd_addr = r_row + 1'b1;
                n_row = rd_addr;
            end
        end

        if (i_cmd.modify) begin
            res_valid = 1'b1;
            if (page_ext >= 32'(lim)) begin
                res_status = pfra_pkg::STAT_OUT_RANGE;
            end else if (r_page == '0) begin
                res_resv = 1'b1;
            end else begin
                case (r_func)
                    pfra_pkg::FUNC_REF: begin
                        if (cur == MARK) begin
                            res_status = pfra_pkg::STAT_RESERVED;
                            res_resv = 1'b1;
                        end else if (cur == '0) begin
                            res_status = pfra_pkg::STAT_ALR_FREE;
                        end else if (cur == MARK - 1'b1) begin
                            res_status = pfra_pkg::STAT_OVERFLOW;
                            res_cnt = cur;
                        end else begin
                            wr_en = 1'b1;
                            wr_val = cur + 1'b1;
                            res_cnt = cur + 1'b1;
                        end
                    end
                    pfra_pkg::FUNC_UNREF: begin
                        if (cur == MARK) begin
                            res_status = pfra_pkg::STAT_RESERVED;
                            res_resv = 1'b1;
                        end else if (cur == '0) begin
                            res_status = pfra_pkg::STAT_ALR_FREE;
                        end else begin
                            wr_en = 1'b1;
                            wr_val = cur - 1'b1;
                            res_cnt = cur - 1'b1;
                            if ((cur == COUNT_WIDTH'(1)) && (r_used != '0)) begin
                                n_used = r_used - 1'b1;
                            end
                        end
                    end
                    pfra_pkg::FUNC_RESERVE: begin
                        res_resv = 1'b1;
                        if (cur == MARK) begin
                            res_status = pfra_pkg::STAT_ALR_RESV;
                        end else begin
                            wr_en = 1'b1;
                            wr_val = MARK;
                            if (cur == '0) begin
                                n_used = r_used + 1'b1;
                            end
                        end
                    end
                    default: begin
                        res_status = pfra_pkg::STAT_OK;
                    end
                endcase
            end
        end
    end

    always_comb begin
        wr_data = r_rdata;
        wr_data[wr_lane * COUNT_WIDTH +: COUNT_WIDTH] = wr_val;
        if (i_cmd.clr_step) begin
            wr_data = '0;
        end
    end

    assign res_free = (lim > n_used) ? (lim - n_used) : '0;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_row] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= pfra_pkg::t_func'(i_func);
            r_page <= i_page_number;
        end
        if (res_valid) begin
            r_status <= res_status;
            r_granted <= res_granted;
            r_cnt <= res_cnt;
            r_resv <= res_resv;
            r_free <= res_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_used <= '0;
            r_page_count <= pfra_pkg::CFG_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_row <= n_row;
            r_used <= n_used;
            r_strobe <= res_valid;
            if (i_cfg_valid) begin
                r_page_count <= i_cfg_data;
            end
        end
    end

    assign o_status_bus.clr_last = (r_row == LAST_ROW);
    assign o_status_bus.scan_done = scan_done;
    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_granted_page = r_granted;
    assign o_ref_count = r_cnt;
    assign o_is_reserved = r_resv;
    assign o_used_pages = r_used;
    assign o_free_pages = r_free;

endmodule

[hw/rtl/page_frame_refcount_allocator_unit.sv]
// Top level of the page frame reference count allocator.
// Reference, unreference and reserve read the addressed row on accept, update it in
// the modify state and register the result strobe. Allocate scans rows of 16 counts
// through one read port of the count store until it finds a free page or the limit.
// A new word is accepted in the cycle the result strobe is high; results cannot stall.
// After reset a clearing pass that zeroes every row of the count store holds busy high.
module page_frame_refcount_allocator_unit #(
    parameter int NUM_PAGES = 1024,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [pfra_pkg::FUNC_W-1:0]    i_func,
    input  logic [pfra_pkg::PAGE_W-1:0]    i_page_number,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pfra_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                           o_strobe,
    output logic [pfra_pkg::STAT_W-1:0]    o_status,
    output logic [pfra_pkg::PAGE_W-1:0]    o_granted_page,
    output logic [COUNT_WIDTH-1:0]         o_ref_count,
    output logic                           o_is_reserved,
    output logic [pfra_pkg::CFG_W-1:0]     o_used_pages,
    output logic [pfra_pkg::CFG_W-1:0]     o_free_pages
);

    pfra_pkg::t_dp_cmd    cmd;
    pfra_pkg::t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    pfra_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_func   (i_func),
        .i_status (dp_status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    pfra_dp #(
        .NUM_PAGES   (NUM_PAGES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status_bus   (dp_status),
        .i_func         (i_func),
        .i_page_number  (i_page_number),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_granted_page (o_granted_page),
        .o_ref_count    (o_ref_count),
        .o_is_reserved  (o_is_reserved),
        .o_used_pages   (o_used_pages),
        .o_free_pages   (o_free_pages)
    );

endmodule
